>>> src/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared codes, defaults and control record of the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int CMD_BITS  = 4;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_INC      = 4'd4,
        CMD_DEC      = 4'd5,
        CMD_MIN      = 4'd6,
        CMD_MAX      = 4'd7,
        CMD_COMPARE  = 4'd8,
        CMD_FROM_INT = 4'd9,
        CMD_TO_INT   = 4'd10
    } t_cmd;

    // what the back end still has to do with an item
    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_MUL  = 2'd1,
        KIND_DIV  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  neg;
        logic  lt;
        logic  eq;
        logic  gt;
        logic  ovf;
        logic  dbz;
    } t_ctl;

endpackage

>>> src/fxalu_if.sv
// ----------------------------------------------------------------------------
// fxalu_in_if / fxalu_out_if
// Valid/ready channels for commands and results of the fixed-point ALU.
// ----------------------------------------------------------------------------
interface fxalu_in_if #(
    parameter int WORD_BITS = fxalu_pkg::WORD_BITS
);
    logic                           valid;
    logic                           ready;
    logic [fxalu_pkg::CMD_BITS-1:0] command;
    logic signed [WORD_BITS-1:0]    operand_a;
    logic signed [WORD_BITS-1:0]    operand_b;

    modport source (output valid, command, operand_a, operand_b, input ready);
    modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fxalu_out_if #(
    parameter int WORD_BITS = fxalu_pkg::WORD_BITS
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] value;
    logic                        is_less;
    logic                        is_equal;
    logic                        is_greater;
    logic                        overflow;
    logic                        divide_by_zero;

    modport source (output valid, value, is_less, is_equal, is_greater, overflow,
                    divide_by_zero, input ready);
    modport sink   (input valid, value, is_less, is_equal, is_greater, overflow,
                    divide_by_zero, output ready);
endinterface

>>> src/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Signed Q24.8 ALU: add, sub, mul, div, inc, dec, min, max, compare, from_int,
// to_int with saturation; mul and div round half away from zero, to_int floors.
// ----------------------------------------------------------------------------
// Path: the queue slot is written at the accept edge, then a Q24.8 item
//   passes one divider stage per quotient bit and a final round stage.
// Throughput: one item per cycle (fully pipelined divider) while results are taken.
// Every command takes the same path, so results leave in order.
// Reset: synchronous, active low; clears queue fill and pipeline valid bits only.
module fixed_point_q24_8_alu #(
    parameter int WORD_BITS = fxalu_pkg::WORD_BITS,
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fxalu_in_if.sink    i_in,
    fxalu_out_if.source o_out
);
    // front end output, straight into the queue
    fxalu_pkg::t_ctl        f_ctl;
    logic [WORD_BITS-1:0]   f_mag_a, f_mag_b, f_val;

    // queue head towards the back end
    logic                   q_valid, q_pop;
    fxalu_pkg::t_ctl        q_ctl;
    logic [WORD_BITS-1:0]   q_mag_a, q_mag_b, q_val;

    // classify and finish the one-step commands combinationally
    fxalu_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_command (i_in.command),
        .i_a       (i_in.operand_a),
        .i_b       (i_in.operand_b),
        .o_ctl     (f_ctl),
        .o_mag_a   (f_mag_a),
        .o_mag_b   (f_mag_b),
        .o_val     (f_val)
    );

    // queue decouples input acceptance from output back-pressure
    fxalu_queue #(
        .WORD_BITS (WORD_BITS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_in.valid && i_in.ready),
        .i_ctl     (f_ctl),
        .i_mag_a   (f_mag_a),
        .i_mag_b   (f_mag_b),
        .i_val     (f_val),
        .o_ready   (i_in.ready),
        .i_pop     (q_pop),
        .o_valid   (q_valid),
        .o_ctl     (q_ctl),
        .o_mag_a   (q_mag_a),
        .o_mag_b   (q_mag_b),
        .o_val     (q_val)
    );

    // multiply, divide, round and saturate; drives the result channel
    fxalu_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_ctl     (q_ctl),
        .i_mag_a   (q_mag_a),
        .i_mag_b   (q_mag_b),
        .i_val     (q_val),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );
endmodule

>>> src/fxalu_front.sv
// ----------------------------------------------------------------------------
// fxalu_front
// Decodes a command, finishes the single-step operations and prepares
// magnitudes and result sign for multiply and divide.
// ----------------------------------------------------------------------------
module fxalu_front #(
    parameter int WORD_BITS = fxalu_pkg::WORD_BITS,
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS
) (
    input  logic [fxalu_pkg::CMD_BITS-1:0] i_command,
    input  logic [WORD_BITS-1:0]           i_a,
    input  logic [WORD_BITS-1:0]           i_b,
    output fxalu_pkg::t_ctl                o_ctl,
    output logic [WORD_BITS-1:0]           o_mag_a,
    output logic [WORD_BITS-1:0]           o_mag_b,
    output logic [WORD_BITS-1:0]           o_val
);
    localparam int W  = WORD_BITS;
    localparam int FW = WORD_BITS + FRAC_BITS;
    localparam logic [W-1:0]  MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [FW-1:0] LIM_P = FW'(MAXV);
    localparam logic [FW-1:0] LIM_N = FW'(MINV);

    fxalu_pkg::t_cmd cmd;
    logic          sub, ovf_as, lt, gt, over_fi;
    logic [W-1:0]  op2, sum;
    logic [FW-1:0] fi;

    always_comb begin
        cmd     = fxalu_pkg::t_cmd'(i_command);
        o_mag_a = i_a[W-1] ? W'(-i_a) : i_a;
        o_mag_b = i_b[W-1] ? W'(-i_b) : i_b;

        sub = (cmd == fxalu_pkg::CMD_SUB) || (cmd == fxalu_pkg::CMD_DEC);
        op2 = ((cmd == fxalu_pkg::CMD_INC) || (cmd == fxalu_pkg::CMD_DEC)) ? W'(1) : i_b;
        sum = sub ? (i_a - op2) : (i_a + op2);
        ovf_as = sub ? ((i_a[W-1] ^ op2[W-1]) & (i_a[W-1] ^ sum[W-1]))
                     : (~(i_a[W-1] ^ op2[W-1]) & (i_a[W-1] ^ sum[W-1]));

        lt = $signed(i_a) < $signed(i_b);
        gt = $signed(i_b) < $signed(i_a);

        fi      = {o_mag_a, {FRAC_BITS{1'b0}}};
        over_fi = i_a[W-1] ? (fi > LIM_N) : (fi > LIM_P);

        o_ctl      = '0;
        o_ctl.kind = fxalu_pkg::KIND_PASS;
        o_ctl.neg  = i_a[W-1] ^ i_b[W-1];
        o_val      = '0;

        case (cmd)
            fxalu_pkg::CMD_ADD, fxalu_pkg::CMD_SUB,
            fxalu_pkg::CMD_INC, fxalu_pkg::CMD_DEC: begin
                o_ctl.ovf = ovf_as;
                o_val     = ovf_as ? (i_a[W-1] ? MINV : MAXV) : sum;
            end
            fxalu_pkg::CMD_MUL: begin
                o_ctl.kind = fxalu_pkg::KIND_MUL;
            end
            fxalu_pkg::CMD_DIV: begin
                if (i_b == '0) begin
                    o_ctl.dbz = 1'b1;
                end else begin
                    o_ctl.kind = fxalu_pkg::KIND_DIV;
                end
            end
            fxalu_pkg::CMD_MIN:     o_val = gt ? i_b : i_a;
            fxalu_pkg::CMD_MAX:     o_val = lt ? i_b : i_a;
            fxalu_pkg::CMD_COMPARE: begin
                o_ctl.lt = lt;
                o_ctl.gt = gt;
                o_ctl.eq = (i_a == i_b);
            end
            fxalu_pkg::CMD_FROM_INT: begin
                o_ctl.ovf = over_fi;
                if (over_fi) begin
                    o_val = i_a[W-1] ? MINV : MAXV;
                end else begin
                    o_val = i_a[W-1] ? W'(-fi[W-1:0]) : fi[W-1:0];
                end
            end
            fxalu_pkg::CMD_TO_INT:  o_val = W'($signed(i_a) >>> FRAC_BITS);
            default:                o_val = '0;
        endcase
    end
endmodule

>>> src/fxalu_queue.sv
// ----------------------------------------------------------------------------
// fxalu_queue
// Two-entry queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module fxalu_queue #(
    parameter int WORD_BITS = fxalu_pkg::WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  fxalu_pkg::t_ctl      i_ctl,
    input  logic [WORD_BITS-1:0] i_mag_a,
    input  logic [WORD_BITS-1:0] i_mag_b,
    input  logic [WORD_BITS-1:0] i_val,
    output logic                 o_ready,
    input  logic                 i_pop,
    output logic                 o_valid,
    output fxalu_pkg::t_ctl      o_ctl,
    output logic [WORD_BITS-1:0] o_mag_a,
    output logic [WORD_BITS-1:0] o_mag_b,
    output logic [WORD_BITS-1:0] o_val
);
    localparam int PW = $bits(fxalu_pkg::t_ctl) + 3 * WORD_BITS;

    logic [PW-1:0] r_head, r_tail, p_in;
    logic [1:0]    r_cnt, n_cnt;
    logic          pop;

    assign p_in    = {i_ctl, i_mag_a, i_mag_b, i_val};
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = i_pop && o_valid;
    assign {o_ctl, o_mag_a, o_mag_b, o_val} = r_head;

    always_comb begin
        n_cnt = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_cnt == 2'd2) begin
                r_head <= r_tail;
            end else if (i_push) begin
                r_head <= p_in;
            end
        end else if (i_push && r_cnt == 2'd0) begin
            r_head <= p_in;
        end
        if (i_push && ((r_cnt == 2'd2 && pop) || (r_cnt == 2'd1 && !pop))) begin
            r_tail <= p_in;
        end
    end
endmodule

>>> src/fxalu_back.sv
// ----------------------------------------------------------------------------
// fxalu_back
// Pipelined multiply and one-bit-per-stage restoring divider with rounding
// and saturation; single-step results ride along.
// ----------------------------------------------------------------------------
module fxalu_back #(
    parameter int WORD_BITS = fxalu_pkg::WORD_BITS,
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  fxalu_pkg::t_ctl      i_ctl,
    input  logic [WORD_BITS-1:0] i_mag_a,
    input  logic [WORD_BITS-1:0] i_mag_b,
    input  logic [WORD_BITS-1:0] i_val,
    output logic                 o_pop,
    fxalu_out_if.source          o_out
);
    localparam int W  = WORD_BITS;
    localparam int QW = WORD_BITS + FRAC_BITS + 1;   // quotient bits
    localparam int MT = 2 * WORD_BITS + 1 - FRAC_BITS;
    localparam int S  = QW + 1;                      // divider stages + final

    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W:0] sat_mul(input logic neg, input logic [MT-1:0] t);
        logic over;
        over = neg ? (t > MT'(MINV)) : (t > MT'(MAXV));
        if (over) begin
            return {1'b1, neg ? MINV : MAXV};
        end
        return {1'b0, neg ? W'(-t[W-1:0]) : t[W-1:0]};
    endfunction

    function automatic logic [W:0] sat_div(input logic neg, input logic [QW-1:0] t);
        logic over;
        over = neg ? (t > QW'(MINV)) : (t > QW'(MAXV));
        if (over) begin
            return {1'b1, neg ? MINV : MAXV};
        end
        return {1'b0, neg ? W'(-t[W-1:0]) : t[W-1:0]};
    endfunction

    logic                    en;
    logic [2*W-1:0]          r_prod;
    logic [2*W:0]            prod_rnd;
    logic [W:0]              mul_res;
    logic                    r_vld [S];
    fxalu_pkg::t_ctl         r_ctl [S];
    logic [W-1:0]            r_val [S];
    logic [W-1:0]            r_d   [S];
    logic [W-1:0]            r_rem [S];
    logic [QW-1:0]           r_nq  [S];

    // whole pipe advances together; stalls only when a result is waiting
    assign en    = !r_vld[S-1] || o_out.ready;
    assign o_pop = en;

    assign prod_rnd = {1'b0, r_prod} + (2*W+1)'(1 << (FRAC_BITS - 1));
    assign mul_res  = sat_mul(r_ctl[0].neg, prod_rnd[2*W:FRAC_BITS]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= i_mag_a * i_mag_b;
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_stage
        logic            s_vld;
        fxalu_pkg::t_ctl s_ctl;
        logic [W-1:0]    s_val, s_d, s_rem;
        logic [QW-1:0]   s_nq;

        if (k == 0) begin : g_src_in
            assign s_vld = i_valid;
            assign s_ctl = i_ctl;
            assign s_val = i_val;
            assign s_d   = i_mag_b;
            assign s_rem = '0;
            assign s_nq  = {i_mag_a, {(FRAC_BITS+1){1'b0}}};
        end else begin : g_src_prev
            assign s_vld = r_vld[k-1];
            assign s_d   = r_d[k-1];
            assign s_rem = r_rem[k-1];
            assign s_nq  = r_nq[k-1];
            if (k == 1) begin : g_mul_merge
                always_comb begin
                    s_ctl = r_ctl[0];
                    s_val = r_val[0];
                    if (r_ctl[0].kind == fxalu_pkg::KIND_MUL) begin
                        s_ctl.ovf  = mul_res[W];
                        s_ctl.kind = fxalu_pkg::KIND_PASS;
                        s_val      = mul_res[W-1:0];
                    end
                end
            end else begin : g_pass
                assign s_ctl = r_ctl[k-1];
                assign s_val = r_val[k-1];
            end
        end

        if (k < QW) begin : g_div_step
            logic [W:0] rs;
            logic       ge;
            assign rs = {s_rem, s_nq[QW-1]};
            assign ge = (rs >= {1'b0, s_d});

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_ctl[k] <= s_ctl;
                    r_val[k] <= s_val;
                    r_d[k]   <= s_d;
                    r_rem[k] <= ge ? W'(rs - {1'b0, s_d}) : rs[W-1:0];
                    r_nq[k]  <= {s_nq[QW-2:0], ge};
                end
            end
        end else begin : g_final
            logic [QW:0]     q_rnd;
            logic [W:0]      div_res;
            fxalu_pkg::t_ctl f_ctl;
            logic [W-1:0]    f_val;
            assign q_rnd   = {1'b0, s_nq} + (QW+1)'(1);
            assign div_res = sat_div(s_ctl.neg, q_rnd[QW:1]);

            // divide result replaces the carried value
            always_comb begin
                f_ctl = s_ctl;
                f_val = s_val;
                if (s_ctl.kind == fxalu_pkg::KIND_DIV) begin
                    f_ctl.ovf = div_res[W];
                    f_val     = div_res[W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_ctl[k] <= f_ctl;
                    r_val[k] <= f_val;
                    r_d[k]   <= s_d;
                    r_rem[k] <= s_rem;
                    r_nq[k]  <= s_nq;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= s_vld;
            end
        end
    end

    assign o_out.valid          = r_vld[S-1];
    assign o_out.value          = r_val[S-1];
    assign o_out.is_less        = r_ctl[S-1].lt;
    assign o_out.is_equal       = r_ctl[S-1].eq;
    assign o_out.is_greater     = r_ctl[S-1].gt;
    assign o_out.overflow       = r_ctl[S-1].ovf;
    assign o_out.divide_by_zero = r_ctl[S-1].dbz;
endmodule

>>> tb/sv/fxalu_checker.sv
// ----------------------------------------------------------------------------
// fxalu_checker
// Watches the command and result channels of the Q24.8 ALU, works out the
// expected result of every accepted command and compares it field by field.
// ----------------------------------------------------------------------------
module fxalu_checker
    import fxalu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fxalu_in_if.sink    i_in,
    fxalu_out_if.sink   i_out,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_accepted
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] value;
        logic                        lt;
        logic                        eq;
        logic                        gt;
        logic                        ovf;
        logic                        dbz;
    } t_alu_result;

    localparam logic signed [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MAX_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    t_alu_result expected_results[$];
    int          fail_count = 0;

    // Clamp a wide signed value into the word, flagging saturation.
    function automatic void clamp_word(input logic signed [127:0] wide,
                                       ref t_alu_result r);
        if (wide > 128'(signed'(MAX_POS))) begin
            r.value = MAX_POS;
            r.ovf   = 1'b1;
        end else if (wide < 128'(signed'(MAX_NEG))) begin
            r.value = MAX_NEG;
            r.ovf   = 1'b1;
        end else begin
            r.value = wide[WORD_BITS-1:0];
        end
    endfunction

    function automatic t_alu_result alu_predict(input logic [CMD_BITS-1:0] cmd,
                                                input logic signed [WORD_BITS-1:0] a,
                                                input logic signed [WORD_BITS-1:0] b);
        t_alu_result      r;
        logic signed [127:0] wa, wb, wide;
        logic [127:0]     ma, mb, mq;
        logic             neg;
        r  = '0;
        wa = a;
        wb = b;
        ma = (wa < 0) ? -wa : wa;
        mb = (wb < 0) ? -wb : wb;
        neg = (wa < 0) != (wb < 0);
        case (cmd)
            CMD_ADD:      clamp_word(wa + wb, r);
            CMD_SUB:      clamp_word(wa - wb, r);
            CMD_INC:      clamp_word(wa + 1, r);
            CMD_DEC:      clamp_word(wa - 1, r);
            CMD_MUL: begin
                // magnitude product, round half away from zero
                mq   = (ma * mb + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                wide = neg ? -signed'(mq) : signed'(mq);
                clamp_word(wide, r);
            end
            CMD_DIV: begin
                if (b == 0) begin
                    r.dbz = 1'b1;
                end else begin
                    // one extra quotient bit for the half step
                    mq   = (((ma << (FRAC_BITS + 1)) / mb) + 1) >> 1;
                    wide = neg ? -signed'(mq) : signed'(mq);
                    clamp_word(wide, r);
                end
            end
            CMD_MIN:      r.value = (b < a) ? b : a;
            CMD_MAX:      r.value = (a < b) ? b : a;
            CMD_COMPARE: begin
                r.lt = a < b;
                r.eq = a == b;
                r.gt = a > b;
            end
            CMD_FROM_INT: clamp_word(wa <<< FRAC_BITS, r);
            CMD_TO_INT:   r.value = a >>> FRAC_BITS;
            default:      r = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n && i_in.valid && i_in.ready)
            expected_results.push_back(alu_predict(i_in.command, i_in.operand_a,
                                                   i_in.operand_b));
        if (i_rst_n && i_out.valid && i_out.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no command outstanding");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (i_out.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, i_out.value);
                    fail_count++;
                end
                if (i_out.is_less !== want.lt) begin
                    $error("is_less: expected %0b, got %0b", want.lt, i_out.is_less);
                    fail_count++;
                end
                if (i_out.is_equal !== want.eq) begin
                    $error("is_equal: expected %0b, got %0b", want.eq, i_out.is_equal);
                    fail_count++;
                end
                if (i_out.is_greater !== want.gt) begin
                    $error("is_greater: expected %0b, got %0b", want.gt,
                           i_out.is_greater);
                    fail_count++;
                end
                if (i_out.overflow !== want.ovf) begin
                    $error("overflow: expected %0b, got %0b", want.ovf, i_out.overflow);
                    fail_count++;
                end
                if (i_out.divide_by_zero !== want.dbz) begin
                    $error("divide_by_zero: expected %0b, got %0b", want.dbz,
                           i_out.divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    assign o_fail_count = fail_count + expected_results.size() * 0;
    assign o_pending    = expected_results.size();
    assign o_accepted   = i_rst_n && ((i_in.valid && i_in.ready) ||
                                      (i_out.valid && i_out.ready));

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random commands into the Q24.8 ALU with random gaps and
// stalls on both channels; the checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import fxalu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY      = WORD_BITS + FRAC_BITS + 3;
    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_LIMIT   = 20000;   // cycles with no item moving

    localparam logic signed [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] MAX_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fxalu_in_if  cmd_ch ();
    fxalu_out_if res_ch ();

    int   fail_count;
    int   pending;
    logic accepted;
    bit   long_hold = 1'b0;    // set by the stimulus to ask for a long result stall
    bit   run_done  = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    fixed_point_q24_8_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source)
    );

    fxalu_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (cmd_ch.sink),
        .i_out        (res_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_accepted   (accepted)
    );

    initial begin
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_ADD;
        cmd_ch.operand_a = '0;
        cmd_ch.operand_b = '0;
        res_ch.ready     = 1'b0;
    end

    // Send one command; gap first, then hold valid until it is taken.
    task automatic send_cmd(input logic [CMD_BITS-1:0] cmd,
                            input logic signed [WORD_BITS-1:0] a,
                            input logic signed [WORD_BITS-1:0] b,
                            input int gap);
        repeat (gap) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= cmd;
        cmd_ch.operand_a <= a;
        cmd_ch.operand_b <= b;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    // Operands biased toward the interesting corners: limits, small values,
    // exact integers and whole random words.
    function automatic logic signed [WORD_BITS-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
            1:       return $signed($urandom_range(0, 1024)) - 512;
            2:       return ($signed($urandom_range(0, 200)) - 100) <<< FRAC_BITS;
            3:       return $signed($urandom) >>> $urandom_range(0, 30);
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stall per item, plus one long hold-off when asked.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                repeat (3 * LATENCY) @(posedge i_clk);
                long_hold = 1'b0;
            end
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if (accepted) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [CMD_BITS-1:0] cmd;
        int gap;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: limits of every operation and the named special cases
        send_cmd(CMD_ADD, MAX_POS, 1, 0);                 // positive saturation
        send_cmd(CMD_SUB, MAX_NEG, 1, 0);                 // negative saturation
        send_cmd(CMD_ADD, -1, -1, 0);
        send_cmd(CMD_MUL, MAX_NEG, MAX_NEG, 0);
        send_cmd(CMD_MUL, 32'sd384, -32'sd128, 0);        // -0.75 exactly, no rounding
        send_cmd(CMD_MUL, -1, 1, 0);
        send_cmd(CMD_DIV, MAX_POS, 0, 0);                 // divide by zero
        send_cmd(CMD_DIV, MAX_NEG, 1, 0);                 // quotient too large
        send_cmd(CMD_DIV, -32'sd256, 32'sd512, 0);        // -0.5 exactly
        send_cmd(CMD_DIV, 32'sd1, MAX_NEG, 0);
        send_cmd(CMD_INC, MAX_POS, 0, 0);
        send_cmd(CMD_DEC, MAX_NEG, 0, 0);
        send_cmd(CMD_MIN, MAX_NEG, MAX_POS, 0);
        send_cmd(CMD_MAX, MAX_NEG, MAX_POS, 0);
        send_cmd(CMD_COMPARE, -5, 5, 0);
        send_cmd(CMD_COMPARE, 7, 7, 0);
        send_cmd(CMD_COMPARE, MAX_POS, MAX_NEG, 0);
        send_cmd(CMD_FROM_INT, 32'sh0080_0000, 0, 0);     // just out of range
        send_cmd(CMD_FROM_INT, -32'sh0080_0000, 0, 0);    // exactly the limit
        send_cmd(CMD_TO_INT, -1, 0, 0);                   // floors toward minus infinity
        send_cmd(CMD_TO_INT, MAX_NEG, 0, 0);
        send_cmd(4'd11, MAX_POS, MAX_POS, 0);             // unused codes
        send_cmd(4'd15, -1, -1, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // one long result stall while commands keep coming
            if (n == 300) long_hold = 1'b1;
            // once, drain everything before carrying on
            if (n == 800) begin
                cmd_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                               : 4'($urandom_range(0, 10));
            gap = (n >= 300 && n < 420) ? 0
                : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14));
            send_cmd(cmd, pick_operand(), ($urandom_range(0, 15) == 0) ? '0
                                                                     : pick_operand(), gap);
        end
        cmd_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/fxalu_pkg.sv
src/fxalu_if.sv
src/fxalu_front.sv
src/fxalu_queue.sv
src/fxalu_back.sv
src/fixed_point_q24_8_alu.sv
tb/sv/fxalu_checker.sv
tb/sv/tb_top.sv
